// ----- rtl/core/dtq_pkg.sv -----
// Shared types and constants of the deadline timer queue.
package dtq_pkg;

	localparam int ID_W = 8;
	localparam int TIME_W = 48;
	localparam int IVL_W = 32;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [ID_W-1:0]   timer_id;
		logic [TIME_W-1:0] deadline_us;
		logic [IVL_W-1:0]  interval_us;
		logic [TIME_W-1:0] now_us;
	} req_t;

	typedef struct packed {
		logic              expired_valid;
		logic [ID_W-1:0]   expired_timer_id;
		logic              earliest_changed;
		logic              add_rejected;
		logic              next_valid;
		logic [TIME_W-1:0] next_deadline_us;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic load_item;
		logic start_scan;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic is_check;
		logic pick_found;
		logic out_free;
	} ctl_sts_t;

endpackage

// ----- rtl/core/dtq_ctrl.sv -----
// Sequencer of the timer queue: accepts a request, runs slot scans and issues results.
module dtq_ctrl
	import dtq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_item = 1'b1;
					cmd.start_scan = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					// Every expired timer found triggers another pass over the table.
					if (sts.is_check && sts.pick_found) begin
						cmd.start_scan = 1'b1;
						state_d = ST_SCAN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result issued while the output register is occupied");
	a_done_leaves_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_done) |=> state_q == ST_EMIT)
		else $error("scan completion not followed by a result");
`endif

endmodule

// ----- rtl/core/dtq_datapath.sv -----
// Slot table, scan comparators, rearm adder and output register of the timer queue.
module dtq_datapath
	import dtq_pkg::*;
#(
	parameter int TIMER_SLOTS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rsp_t     rsp
);

	localparam int SW = $clog2(TIMER_SLOTS);
	localparam logic [SW-1:0] LAST_IDX = SW'(TIMER_SLOTS - 1);

	// Slot storage, read one entry per cycle during a scan.
	logic [TIME_W-1:0] mem_dl [TIMER_SLOTS];
	logic [IVL_W-1:0]  mem_iv [TIMER_SLOTS];
	logic [ID_W-1:0]   mem_id [TIMER_SLOTS];

	logic [TIMER_SLOTS-1:0] used_q;
	logic [TIMER_SLOTS-1:0] due_q;

	req_t item_q;
	logic first_q;

	logic          issuing_q;
	logic [SW-1:0] rd_idx_q;
	logic          valid_s1;
	logic [SW-1:0] idx_s1;
	logic [TIME_W-1:0] dl_s1;
	logic [IVL_W-1:0]  iv_s1;
	logic [ID_W-1:0]   id_s1;

	logic              pick_found_q;
	logic [SW-1:0]     pick_idx_q;
	logic [TIME_W-1:0] pick_dl_q;
	logic [IVL_W-1:0]  pick_iv_q;
	logic [ID_W-1:0]   pick_id_q;
	logic              min_valid_q;
	logic [TIME_W-1:0] min_dl_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic              is_check;
	logic              full;
	logic [SW-1:0]     free_idx;
	logic              used_i;
	logic              due_now;
	logic              cand;
	logic              wr_add;
	logic              wr_rearm;
	logic              mem_we;
	logic [SW-1:0]     mem_wa;
	logic [TIME_W-1:0] mem_wd;
	logic [TIME_W:0]   rearm_sum;
	logic [TIME_W-1:0] rearm_dl;
	rsp_t              rsp_d;

	assign is_check = (item_q.cmd == CMD_CHECK);
	assign full = &used_q;

	always_comb begin
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = SW'(i);
			end
		end
	end

	assign used_i = used_q[idx_s1];
	assign due_now = used_i && (dl_s1 <= item_q.now_us);
	assign cand = is_check && (first_q ? due_now : due_q[idx_s1]);

	assign rearm_sum = {1'b0, item_q.now_us} + (TIME_W + 1)'(pick_iv_q);
	assign rearm_dl = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];

	assign wr_add = cmd.emit && !is_check && !full;
	assign wr_rearm = cmd.emit && is_check && pick_found_q;
	assign mem_we = wr_add || (wr_rearm && (pick_iv_q != '0));
	assign mem_wa = wr_add ? free_idx : pick_idx_q;
	assign mem_wd = wr_add ? item_q.deadline_us : rearm_dl;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_dl[mem_wa] <= mem_wd;
		end
		if (wr_add) begin
			mem_iv[free_idx] <= item_q.interval_us;
			mem_id[free_idx] <= item_q.timer_id;
		end
		if (issuing_q) begin
			dl_s1 <= mem_dl[rd_idx_q];
			iv_s1 <= mem_iv[rd_idx_q];
			id_s1 <= mem_id[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req;
		end
		if (cmd.start_scan) begin
			rd_idx_q <= '0;
		end else if (issuing_q) begin
			rd_idx_q <= rd_idx_q + SW'(1);
		end
		if (issuing_q) begin
			idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			valid_s1 <= 1'b0;
			first_q <= 1'b0;
		end else begin
			valid_s1 <= issuing_q;
			if (cmd.start_scan) begin
				issuing_q <= 1'b1;
			end else if (issuing_q && rd_idx_q == LAST_IDX) begin
				issuing_q <= 1'b0;
			end
			if (cmd.load_item) begin
				first_q <= 1'b1;
			end else if (cmd.emit) begin
				first_q <= 1'b0;
			end
		end
	end

	// Running minima: the earliest due timer (ties keep the lower slot) and
	// the earliest pending deadline of the table as it stands in this pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_found_q <= 1'b0;
			min_valid_q <= 1'b0;
		end else if (cmd.start_scan) begin
			pick_found_q <= 1'b0;
			min_valid_q <= 1'b0;
		end else if (valid_s1) begin
			if (cand && (!pick_found_q || dl_s1 < pick_dl_q)) begin
				pick_found_q <= 1'b1;
			end
			if (used_i) begin
				min_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (cand && (!pick_found_q || dl_s1 < pick_dl_q)) begin
				pick_idx_q <= idx_s1;
				pick_dl_q <= dl_s1;
				pick_iv_q <= iv_s1;
				pick_id_q <= id_s1;
			end
			if (used_i && (!min_valid_q || dl_s1 < min_dl_q)) begin
				min_dl_q <= dl_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			due_q <= '0;
		end else begin
			if (valid_s1 && first_q && is_check) begin
				due_q[idx_s1] <= due_now;
			end
			if (wr_add) begin
				used_q[free_idx] <= 1'b1;
			end
			if (wr_rearm) begin
				due_q[pick_idx_q] <= 1'b0;
				if (pick_iv_q == '0) begin
					used_q[pick_idx_q] <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		rsp_d = '0;
		if (!is_check) begin
			rsp_d.earliest_changed = !full && (!min_valid_q || item_q.deadline_us < min_dl_q);
			rsp_d.add_rejected = full;
			rsp_d.next_valid = 1'b1;
			if (full || (min_valid_q && min_dl_q <= item_q.deadline_us)) begin
				rsp_d.next_deadline_us = min_dl_q;
			end else begin
				rsp_d.next_deadline_us = item_q.deadline_us;
			end
			rsp_d.last = 1'b1;
		end else if (pick_found_q) begin
			rsp_d.expired_valid = 1'b1;
			rsp_d.expired_timer_id = pick_id_q;
		end else begin
			rsp_d.next_valid = min_valid_q;
			rsp_d.next_deadline_us = min_valid_q ? min_dl_q : '0;
			rsp_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign sts.scan_done = valid_s1 && (idx_s1 == LAST_IDX);
	assign sts.is_check = is_check;
	assign sts.pick_found = pick_found_q;
	assign sts.out_free = !rsp_valid_q || rsp_ready;

`ifndef ASSERT_OFF
	a_due_only_used: assert property (@(posedge clk) disable iff (!arst_n)
		(due_q & ~used_q) == '0)
		else $error("due flag set on a free slot");
	a_add_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_add |=> $countones(used_q) == $past($countones(used_q)) + 1)
		else $error("accepted add did not occupy a slot");
	a_expired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.expired_valid) |-> !rsp_q.last)
		else $error("expired timer result marked as final");
	a_pick_is_due: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.scan_done && is_check && !first_q && pick_found_q) |=> due_q[pick_idx_q])
		else $error("selected timer is not due");
`endif

endmodule

// ----- rtl/core/deadline_timer_queue_top.sv -----
// Top level of the deadline timer queue.
//
// The queue holds TIMER_SLOTS timers in a single-port-read slot table and handles one
// request at a time. Every request runs one or more passes over the table, one slot read
// per cycle; each pass ends with its result loaded into the output register, after
// which the sequencer returns to idle or starts the next pass. An add runs one pass, and
// a check that finds E expired timers runs E + 1 passes, one per expired timer reported
// in deadline order plus a final pass that produces the next deadline. A result waiting
// on rsp_ready stalls the sequence. Occupancy lives in flip-flops cleared by reset, so
// the block is ready right after reset with no clearing pass.
module deadline_timer_queue_top
	import dtq_pkg::*;
#(
	parameter int TIMER_SLOTS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	dtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dtq_datapath #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- test/tb_deadline_timer_queue_top.sv -----
// Self-checking testbench of the deadline timer queue with a transaction-level timer table.
`timescale 1ns / 100ps

module tb_deadline_timer_queue_top;
	import dtq_pkg::*;

	localparam int TIMER_SLOTS = 32;
	localparam int PASS_CYCLES = TIMER_SLOTS + 2;
	localparam int QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Timer table as the block should hold it after every accepted request.
	logic              tt_used     [TIMER_SLOTS];
	logic [TIME_W-1:0] tt_deadline [TIMER_SLOTS];
	logic [IVL_W-1:0]  tt_interval [TIMER_SLOTS];
	logic [ID_W-1:0]   tt_id       [TIMER_SLOTS];

	rsp_t report_q[$];
	int   fail_count;
	int   quiet_cycles;

	deadline_timer_queue_top #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[TIME_W-1:0];
	endfunction

	function automatic void table_earliest(output logic found, output logic [TIME_W-1:0] dl);
		found = 1'b0;
		dl = '0;
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			if (tt_used[i] && (!found || tt_deadline[i] < dl)) begin
				dl = tt_deadline[i];
				found = 1'b1;
			end
		end
	endfunction

	function automatic int table_count();
		int n;
		n = 0;
		for (int i = 0; i < TIMER_SLOTS; i++)
			if (tt_used[i])
				n++;
		return n;
	endfunction

	// Updates the timer table for one request and queues the reports it must produce.
	function automatic void apply_to_timer_table(input req_t r);
		rsp_t res;
		int free_slot;
		int pick;
		logic had;
		logic [TIME_W-1:0] cur;
		logic [TIME_W:0] sum;
		logic due [TIMER_SLOTS];
		res = '0;
		if (r.cmd == CMD_ADD) begin
			free_slot = -1;
			for (int i = 0; i < TIMER_SLOTS; i++)
				if (!tt_used[i] && free_slot < 0)
					free_slot = i;
			if (free_slot < 0) begin
				res.add_rejected = 1'b1;
			end else begin
				table_earliest(had, cur);
				res.earliest_changed = !had || r.deadline_us < cur;
				tt_used[free_slot] = 1'b1;
				tt_deadline[free_slot] = r.deadline_us;
				tt_interval[free_slot] = r.interval_us;
				tt_id[free_slot] = r.timer_id;
			end
		end else begin
			for (int i = 0; i < TIMER_SLOTS; i++)
				due[i] = tt_used[i] && tt_deadline[i] <= r.now_us;
			// Due set is frozen up front, so a rearmed timer cannot show up twice.
			while (1) begin
				pick = -1;
				for (int i = 0; i < TIMER_SLOTS; i++)
					if (due[i] && (pick < 0 || tt_deadline[i] < tt_deadline[pick]))
						pick = i;
				if (pick < 0)
					break;
				due[pick] = 1'b0;
				res = '0;
				res.expired_valid = 1'b1;
				res.expired_timer_id = tt_id[pick];
				report_q.push_back(res);
				if (tt_interval[pick] != '0) begin
					sum = {1'b0, r.now_us} + (TIME_W + 1)'(tt_interval[pick]);
					tt_deadline[pick] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
				end else begin
					tt_used[pick] = 1'b0;
				end
			end
			res = '0;
		end
		res.last = 1'b1;
		table_earliest(res.next_valid, res.next_deadline_us);
		report_q.push_back(res);
	endfunction

	function automatic req_t noise_item();
		req_t it;
		it.cmd = 1'($urandom_range(0, 1));
		it.timer_id = ID_W'($urandom_range(0, 255));
		it.deadline_us = rand48();
		it.interval_us = $urandom();
		it.now_us = rand48();
		return it;
	endfunction

	task automatic send_item(input req_t it);
		@(negedge clk);
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		apply_to_timer_table(it);
	endtask

	task automatic req_pause(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
	endtask

	task automatic wait_reports_drained();
		req_pause(1);
		while (report_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_timer(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] dl,
			input logic [IVL_W-1:0] iv);
		req_t it;
		it = noise_item();
		it.cmd = CMD_ADD;
		it.timer_id = id;
		it.deadline_us = dl;
		it.interval_us = iv;
		send_item(it);
	endtask

	task automatic check_at(input logic [TIME_W-1:0] now);
		req_t it;
		it = noise_item();
		it.cmd = CMD_CHECK;
		it.now_us = now;
		send_item(it);
	endtask

	task automatic test_empty_table();
		check_at('0);
		check_at('1);
	endtask

	task automatic test_earliest_tracking();
		add_timer(8'h00, 48'd1000, '0);
		add_timer(8'hFF, 48'd1000, 32'd5);
		add_timer(8'h5A, 48'd2000, '0);
		add_timer(8'hA5, 48'd500, '0);
		add_timer(8'h01, '0, '1);
		add_timer(8'h02, '1, '0);
	endtask

	task automatic test_expiry_order();
		check_at('0);
		check_at(48'd600);
		check_at(48'd999);
		// Two timers share deadline 1000, so the lower slot must come first.
		check_at(48'd1000);
		// At the top of the time range every rearm saturates.
		check_at('1);
		check_at('1);
	endtask

	task automatic test_table_full();
		req_t it;
		while (table_count() < TIMER_SLOTS) begin
			it = noise_item();
			it.cmd = CMD_ADD;
			if ($urandom_range(0, 9) != 0)
				it.interval_us = '0;
			send_item(it);
		end
		add_timer(ID_W'($urandom_range(0, 255)), '0, '0);
		add_timer(ID_W'($urandom_range(0, 255)), rand48(), $urandom());
		check_at('1);
	endtask

	task automatic test_random_traffic(input int n_items);
		req_t it;
		int burst_left;
		int sel;
		logic found;
		logic [TIME_W-1:0] first_dl;
		logic [TIME_W-1:0] now_base;
		now_base = {16'h0, $urandom()};
		burst_left = $urandom_range(1, 16);
		for (int k = 0; k < n_items; k++) begin
			if (k == n_items / 2)
				wait_reports_drained();
			it = noise_item();
			if ($urandom_range(0, 99) < 55) begin
				it.cmd = CMD_ADD;
				sel = $urandom_range(0, 99);
				if (sel < 80) begin
					it.deadline_us = now_base + TIME_W'($urandom_range(0, 2000));
				end else if (sel < 88) begin
					table_earliest(found, first_dl);
					it.deadline_us = first_dl;
				end else if (sel < 94) begin
					it.deadline_us = rand48();
				end else if (sel < 97) begin
					it.deadline_us = '0;
				end else begin
					it.deadline_us = '1;
				end
				// Repeating timers never leave the table, so keep them rare.
				sel = $urandom_range(0, 99);
				if (sel < 94)
					it.interval_us = '0;
				else if (sel < 98)
					it.interval_us = $urandom_range(1, 500);
				else if (sel < 99)
					it.interval_us = '1;
			end else begin
				it.cmd = CMD_CHECK;
				sel = $urandom_range(0, 99);
				if (sel < 92) begin
					now_base = now_base + TIME_W'($urandom_range(0, 600));
					it.now_us = now_base;
				end else if (sel < 98) begin
					it.now_us = rand48();
				end else begin
					it.now_us = '1;
				end
			end
			send_item(it);
			burst_left--;
			if (burst_left == 0) begin
				req_pause($urandom_range(1, 8));
				burst_left = $urandom_range(1, 16);
			end
		end
	endtask

	// Receiver: alternates between always ready, light stalls and long stalls.
	initial begin
		int mode;
		int mode_left;
		int stall_left;
		rsp_ready = 1'b0;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (mode == 1 && $urandom_range(0, 3) == 0)
					stall_left = $urandom_range(1, 3);
				else if (mode == 2 && $urandom_range(0, 1) == 0)
					stall_left = $urandom_range(1, 12);
			end
		end
	end

	task automatic compare_field(input string fname, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (report_q.size() == 0) begin
				$display("%0t: unexpected result transfer, expected none, actual %0h",
					$time, rsp);
				fail_count++;
			end else begin
				want = report_q.pop_front();
				compare_field("expired_valid", TIME_W'(want.expired_valid),
					TIME_W'(rsp.expired_valid));
				compare_field("expired_timer_id", TIME_W'(want.expired_timer_id),
					TIME_W'(rsp.expired_timer_id));
				compare_field("earliest_changed", TIME_W'(want.earliest_changed),
					TIME_W'(rsp.earliest_changed));
				compare_field("add_rejected", TIME_W'(want.add_rejected),
					TIME_W'(rsp.add_rejected));
				compare_field("next_valid", TIME_W'(want.next_valid),
					TIME_W'(rsp.next_valid));
				compare_field("next_deadline_us", want.next_deadline_us,
					rsp.next_deadline_us);
				compare_field("last", TIME_W'(want.last), TIME_W'(rsp.last));
			end
		end
	end

	// Ends a hung run: counts cycles in which neither channel completes a transfer.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_deadline_timer_queue_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		fail_count = 0;
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			tt_used[i] = 1'b0;
			tt_deadline[i] = '0;
			tt_interval[i] = '0;
			tt_id[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_earliest_tracking();
		test_expiry_order();
		test_table_full();
		test_random_traffic(190);

		wait_reports_drained();
		repeat (2 * PASS_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_deadline_timer_queue_top passed");
		end else begin
			$display("tb_deadline_timer_queue_top failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/dtq_pkg.sv
rtl/core/dtq_ctrl.sv
rtl/core/dtq_datapath.sv
rtl/core/deadline_timer_queue_top.sv
test/tb_deadline_timer_queue_top.sv
